### sv/fbc_pkg.sv
// ============================================================================
// fbc_pkg
// Shared types and constants for the frustum box cull test unit.
// ============================================================================
package fbc_pkg;

    localparam int NORMAL_W = 16;
    localparam int OFFSET_W = 48;
    localparam int FIELD_W  = 32;
    localparam int INDEX_W  = 3;

    // Request operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    typedef enum logic [1:0] {
        CLS_INSIDE     = 2'd0,
        CLS_INTERSECTS = 2'd1,
        CLS_OUTSIDE    = 2'd2
    } cls_t;

    typedef struct packed {
        logic                       operation;
        logic [INDEX_W-1:0]         plane_index;
        logic signed [NORMAL_W-1:0] normal_x;
        logic signed [NORMAL_W-1:0] normal_y;
        logic signed [NORMAL_W-1:0] normal_z;
        logic signed [OFFSET_W-1:0] plane_offset;
        logic signed [FIELD_W-1:0]  min_x;
        logic signed [FIELD_W-1:0]  min_y;
        logic signed [FIELD_W-1:0]  min_z;
        logic signed [FIELD_W-1:0]  max_x;
        logic signed [FIELD_W-1:0]  max_y;
        logic signed [FIELD_W-1:0]  max_z;
    } req_t;

    typedef struct packed {
        cls_t classification;
    } res_t;

    // One stored plane
    typedef struct packed {
        logic signed [NORMAL_W-1:0] normal_x;
        logic signed [NORMAL_W-1:0] normal_y;
        logic signed [NORMAL_W-1:0] normal_z;
        logic signed [OFFSET_W-1:0] offset;
    } plane_t;

    // Stage load enables for the per-plane lanes
    typedef struct packed {
        logic s2_en;
        logic s3_en;
    } lane_ctrl_t;

endpackage

### sv/fbc_req_if.sv
// ============================================================================
// fbc_req_if
// Request channel: plane loads and box tests, valid/ready handshake.
// ============================================================================
interface fbc_req_if;
    logic          valid;
    logic          ready;
    fbc_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/fbc_res_if.sv
// ============================================================================
// fbc_res_if
// Result channel: box classification, valid/ready handshake.
// ============================================================================
interface fbc_res_if;
    logic          valid;
    logic          ready;
    fbc_pkg::res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/fbc_plane_file.sv
// ============================================================================
// fbc_plane_file
// Plane store: one register slot per plane, written by plane-load requests.
// ============================================================================
module fbc_plane_file #(
    parameter int NUM_PLANES = 6
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [fbc_pkg::INDEX_W-1:0]  wr_idx,
    input  fbc_pkg::plane_t              wr_plane,
    output fbc_pkg::plane_t              planes [NUM_PLANES]
);

    fbc_pkg::plane_t planes_reg [NUM_PLANES];

    // Slot write; an index past the last slot matches nothing
    for (genvar i = 0; i < NUM_PLANES; i++) begin : g_slot
        always_ff @(posedge clk)
        begin
            if (wr_en && (int'(wr_idx) == i))
            begin
                planes_reg[i] <= wr_plane;
            end
        end
        assign planes[i] = planes_reg[i];
    end

endmodule

### sv/fbc_plane_lane.sv
// ============================================================================
// fbc_plane_lane
// One plane's datapath: corner pick and products, then distance signs.
// ============================================================================
module fbc_plane_lane #(
    parameter int CW = 32
) (
    input  logic                   clk,
    input  fbc_pkg::lane_ctrl_t    ctrl,
    input  fbc_pkg::plane_t        plane,
    input  logic signed [CW-1:0]   box_lo [3],
    input  logic signed [CW-1:0]   box_hi [3],
    output logic                   p_neg,
    output logic                   n_neg
);

    localparam int PROD_W = fbc_pkg::NORMAL_W + CW;
    localparam int ACC_W  = ((PROD_W > fbc_pkg::OFFSET_W) ? PROD_W : fbc_pkg::OFFSET_W) + 2;

    logic signed [fbc_pkg::NORMAL_W-1:0] nrm [3];
    logic signed [CW-1:0]                pv  [3];
    logic signed [CW-1:0]                nv  [3];
    logic signed [PROD_W-1:0]            prod_p_reg [3];
    logic signed [PROD_W-1:0]            prod_n_reg [3];
    logic signed [fbc_pkg::OFFSET_W-1:0] off_reg;
    logic signed [ACC_W-1:0]             acc_p;
    logic signed [ACC_W-1:0]             acc_n;
    logic                                p_neg_reg;
    logic                                n_neg_reg;

    assign nrm[0] = plane.normal_x;
    assign nrm[1] = plane.normal_y;
    assign nrm[2] = plane.normal_z;

    // p-vertex: max where normal >= 0, else min; n-vertex opposite
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pv[k] = nrm[k][fbc_pkg::NORMAL_W-1] ? box_lo[k] : box_hi[k];
            nv[k] = nrm[k][fbc_pkg::NORMAL_W-1] ? box_hi[k] : box_lo[k];
        end
    end

    // Stage 2: products
    always_ff @(posedge clk)
    begin
        if (ctrl.s2_en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_p_reg[k] <= nrm[k] * pv[k];
                prod_n_reg[k] <= nrm[k] * nv[k];
            end
            off_reg <= plane.offset;
        end
    end

    // Exact distances, wide enough never to overflow
    assign acc_p = ACC_W'(prod_p_reg[0]) + ACC_W'(prod_p_reg[1])
                 + ACC_W'(prod_p_reg[2]) + ACC_W'(off_reg);
    assign acc_n = ACC_W'(prod_n_reg[0]) + ACC_W'(prod_n_reg[1])
                 + ACC_W'(prod_n_reg[2]) + ACC_W'(off_reg);

    // Stage 3: sign flags
    always_ff @(posedge clk)
    begin
        if (ctrl.s3_en)
        begin
            p_neg_reg <= acc_p[ACC_W-1];
            n_neg_reg <= acc_n[ACC_W-1];
        end
    end

    assign p_neg = p_neg_reg;
    assign n_neg = n_neg_reg;

endmodule

### sv/frustum_box_cull_test_unit.sv
// ============================================================================
// frustum_box_cull_test_unit
// Frustum culling of axis-aligned boxes by the p-vertex / n-vertex test.
// ============================================================================
// A box test passes the request, product, sign-flag and result registers.
// Throughput: one request per cycle unless res.ready stalls; all planes
// are tested in parallel lanes. A plane load takes effect for every test
// request accepted after it. Reset clears the pipeline valid bits only;
// plane slots hold garbage until loaded.
module frustum_box_cull_test_unit #(
    parameter int NUM_PLANES  = 6,
    parameter int COORD_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    fbc_req_if.sink     req,
    fbc_res_if.source   res
);

    localparam int CW = (COORD_WIDTH < fbc_pkg::FIELD_W) ? COORD_WIDTH : fbc_pkg::FIELD_W;

    // Stage 1: request register
    logic                         s1_valid_reg, s1_valid_next;
    logic                         s1_op_reg;
    logic [fbc_pkg::INDEX_W-1:0]  s1_idx_reg;
    fbc_pkg::plane_t              s1_plane_reg;
    logic signed [CW-1:0]         s1_lo_reg [3];
    logic signed [CW-1:0]         s1_hi_reg [3];

    logic                         s2_valid_reg, s2_valid_next;
    logic                         s3_valid_reg, s3_valid_next;
    logic                         s4_valid_reg, s4_valid_next;
    fbc_pkg::cls_t                s4_cls_reg, s4_cls_next;

    logic                         rdy1, rdy2, rdy3, rdy4;
    logic                         s1_go;
    logic                         req_fire;
    logic                         plane_wr;
    fbc_pkg::lane_ctrl_t          lane_ctrl;
    fbc_pkg::plane_t              planes [NUM_PLANES];
    logic [NUM_PLANES-1:0]        p_neg;
    logic [NUM_PLANES-1:0]        n_neg;

    // Ready chain, output register at the end
    assign rdy4  = !s4_valid_reg || res.ready;
    assign rdy3  = !s3_valid_reg || rdy4;
    assign rdy2  = !s2_valid_reg || rdy3;
    assign s1_go = s1_valid_reg && ((s1_op_reg == fbc_pkg::OP_LOAD) || rdy2);
    assign rdy1  = !s1_valid_reg || s1_go;

    assign req.ready = rdy1;
    assign req_fire  = req.valid && rdy1;

    // Loads write the store as they leave stage 1, keeping request order
    assign plane_wr = s1_go && (s1_op_reg == fbc_pkg::OP_LOAD);

    assign lane_ctrl.s2_en = s1_go && (s1_op_reg == fbc_pkg::OP_TEST);
    assign lane_ctrl.s3_en = s2_valid_reg && rdy3;

    // Valid bits
    always_comb
    begin
        s1_valid_next = rdy1 ? req.valid : s1_valid_reg;
        s2_valid_next = rdy2 ? lane_ctrl.s2_en : s2_valid_reg;
        s3_valid_next = rdy3 ? s2_valid_reg : s3_valid_reg;
        s4_valid_next = rdy4 ? s3_valid_reg : s4_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
        end
    end

    // Stage 1 payload; coordinates cut to CW bits
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_op_reg             <= req.data.operation;
            s1_idx_reg            <= req.data.plane_index;
            s1_plane_reg.normal_x <= req.data.normal_x;
            s1_plane_reg.normal_y <= req.data.normal_y;
            s1_plane_reg.normal_z <= req.data.normal_z;
            s1_plane_reg.offset   <= req.data.plane_offset;
            s1_lo_reg[0]          <= req.data.min_x[CW-1:0];
            s1_lo_reg[1]          <= req.data.min_y[CW-1:0];
            s1_lo_reg[2]          <= req.data.min_z[CW-1:0];
            s1_hi_reg[0]          <= req.data.max_x[CW-1:0];
            s1_hi_reg[1]          <= req.data.max_y[CW-1:0];
            s1_hi_reg[2]          <= req.data.max_z[CW-1:0];
        end
    end

    fbc_plane_file #(
        .NUM_PLANES (NUM_PLANES)
    ) u_plane_file (
        .clk      (clk),
        .wr_en    (plane_wr),
        .wr_idx   (s1_idx_reg),
        .wr_plane (s1_plane_reg),
        .planes   (planes)
    );

    for (genvar i = 0; i < NUM_PLANES; i++) begin : g_lane
        fbc_plane_lane #(
            .CW (CW)
        ) u_lane (
            .clk    (clk),
            .ctrl   (lane_ctrl),
            .plane  (planes[i]),
            .box_lo (s1_lo_reg),
            .box_hi (s1_hi_reg),
            .p_neg  (p_neg[i]),
            .n_neg  (n_neg[i])
        );
    end

    // Stage 4: combine the lanes; any p-vertex behind a plane means outside
    always_comb
    begin
        if (|p_neg)
            s4_cls_next = fbc_pkg::CLS_OUTSIDE;
        else if (|n_neg)
            s4_cls_next = fbc_pkg::CLS_INTERSECTS;
        else
            s4_cls_next = fbc_pkg::CLS_INSIDE;
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg && rdy4)
        begin
            s4_cls_reg <= s4_cls_next;
        end
    end

    assign res.valid               = s4_valid_reg;
    assign res.data.classification = s4_cls_reg;

    // Assertions
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !rdy3 |=> s2_valid_reg)
        else $error("stage 2 request lost during stall");

    a_test_enters: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && (req.data.operation == fbc_pkg::OP_TEST)
        |=> s1_valid_reg && (s1_op_reg == fbc_pkg::OP_TEST))
        else $error("accepted box test not held in stage 1");

    a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && !rdy4 |=> s3_valid_reg && $stable(p_neg) && $stable(n_neg))
        else $error("lane flags changed under stall");

endmodule
